// File: design/fte_pkg.sv
// Shared types and constants for the FAT12 table engine.
// No dependencies; every other design file imports this package.
`default_nettype none

package fte_pkg;

  localparam int unsigned ENTRY_W = 12;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned TS_W    = 16;

  typedef logic [REQ_W-1:0]   req_kind_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [TS_W-1:0]    sectors_t;

  localparam req_kind_t REQ_READ  = 2'd0;
  localparam req_kind_t REQ_WRITE = 2'd1;
  localparam req_kind_t REQ_COUNT = 2'd2;
  localparam req_kind_t REQ_FIND  = 2'd3;

  localparam sectors_t TS_RESET         = 16'd2880;
  localparam sectors_t RESERVED_SECTORS = 16'd32;
  localparam sectors_t FIRST_DATA_ENTRY = 16'd2;

endpackage

`default_nettype wire

// File: design/fte_if.sv
// Valid/ready channel interfaces for requests and results of the table engine.
// Depends on fte_pkg for payload types.
`default_nettype none

interface fte_req_if
  import fte_pkg::*;
();
  logic      valid;
  logic      ready;
  req_kind_t req_type;
  entry_t    entry_index;
  entry_t    entry_value;

  modport source (output valid, req_type, entry_index, entry_value, input ready);
  modport sink   (input valid, req_type, entry_index, entry_value, output ready);
endinterface

interface fte_rsp_if
  import fte_pkg::*;
();
  logic   valid;
  logic   ready;
  entry_t result_value;
  logic   found;

  modport source (output valid, result_value, found, input ready);
  modport sink   (input valid, result_value, found, output ready);
endinterface

`default_nettype wire

// File: design/fat12_table_engine_unit.sv
// FAT12 allocation table engine: entry read/write, free count, first-free search.
// A count or find scans the data entries of the table with one table read per cycle
// through the single read port of the entry memory.
// One request is in flight at a time; the result register frees the request side.
// Reset: synchronous; a clearing pass then zeroes the whole table, with no request
// taken meanwhile. total_sectors resets to 2880. Depends on fte_pkg and fte_if.
`default_nettype none

module fat12_table_engine_unit
  import fte_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst,
  fte_req_if.sink       req,
  fte_rsp_if.source     rsp,
  input  wire logic     cfg_we,
  input  wire sectors_t cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);
  localparam sectors_t MAX_SPAN = TS_W'(MAX_ENTRIES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Entries occupy disjoint nibbles of the packed byte layout, so the table is
  // kept one 12-bit word per entry; a write leaves its neighbors untouched.
  entry_t mem [MAX_ENTRIES];
  entry_t rdata;

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_idx;
  sectors_t      total_sectors;
  logic          rd_oob;
  logic          is_find;
  logic [AW-1:0] scan_idx;
  logic          iss_on;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic          rd_last;
  logic [AW-1:0] end_m1;
  entry_t        res;
  logic          fnd;
  logic          out_valid;
  entry_t        out_value;
  logic          out_found;

  logic          accept;
  logic          in_range;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  sectors_t      scan_lim;
  logic          scan_empty;
  logic          issue;
  logic          hit;
  logic          load_out;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_range  = ({1'b0, req.entry_index} < (ENTRY_W + 1)'(MAX_ENTRIES));

  // Scan limit: total_sectors minus the reserved area, clamped to zero and to the table size.
  always_comb begin
    if (total_sectors <= RESERVED_SECTORS) begin
      scan_lim = '0;
    end else if ((total_sectors - RESERVED_SECTORS) > MAX_SPAN) begin
      scan_lim = MAX_SPAN;
    end else begin
      scan_lim = total_sectors - RESERVED_SECTORS;
    end
  end
  assign scan_empty = (scan_lim <= FIRST_DATA_ENTRY);

  assign issue    = (state == ST_SCAN) && iss_on;
  assign hit      = rd_pend && (rdata == '0);
  assign load_out = (state == ST_DONE) && (!out_valid || rsp.ready);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_idx;
    mem_wdata = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && (req.req_type == REQ_WRITE) && in_range) begin
      mem_we    = 1'b1;
      mem_waddr = req.entry_index[AW-1:0];
      mem_wdata = req.entry_value;
    end
    mem_raddr = (state == ST_IDLE) ? req.entry_index[AW-1:0] : scan_idx;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_sectors <= TS_RESET;
    end else if (cfg_we) begin
      total_sectors <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == LAST_ADDR) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_READ:  state_next = ST_RD;
            REQ_WRITE: state_next = ST_DONE;
            REQ_COUNT,
            REQ_FIND:  state_next = scan_empty ? ST_DONE : ST_SCAN;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_RD:   state_next = ST_DONE;
      ST_SCAN: if ((hit && is_find) || (rd_pend && rd_last)) state_next = ST_DONE;
      ST_DONE: if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      rd_pend   <= 1'b0;
      iss_on    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      // Track the read issued this cycle; its data is checked next cycle.
      if (state == ST_SCAN) begin
        rd_pend <= issue && (state_next == ST_SCAN);
        if (issue) begin
          iss_on <= (scan_idx != end_m1);
        end
      end else begin
        rd_pend <= 1'b0;
      end
      if (accept && !scan_empty) begin
        iss_on <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_oob   <= !in_range;
      is_find  <= (req.req_type == REQ_FIND);
      scan_idx <= AW'(FIRST_DATA_ENTRY);
      end_m1   <= AW'(scan_lim - 16'd1);
      res      <= '0;
      fnd      <= 1'b0;
    end else if (state == ST_RD) begin
      res <= rd_oob ? '0 : rdata;
    end else if (state == ST_SCAN) begin
      if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (hit && is_find) begin
        res <= ENTRY_W'(rd_idx);
        fnd <= 1'b1;
      end else if (hit) begin
        res <= res + 1'b1;
      end
    end
    if (issue) begin
      rd_idx  <= scan_idx;
      rd_last <= (scan_idx == end_m1);
    end
    if (load_out) begin
      out_value <= res;
      out_found <= fnd;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.found        = out_found;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("request transfer did not start work");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == ST_SCAN)
    else $error("scan read pending outside scan");

  a_found_index: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.result_value >= ENTRY_W'(FIRST_DATA_ENTRY))
    else $error("found index below first data entry");

endmodule

`default_nettype wire
